FILE: design/sac_pkg.sv
`timescale 1ns / 1ps
package sac_pkg;

	localparam int ATLAS_SIZE  = 512;
	localparam int MAX_SHELVES = 64;

	localparam int FW      = 10;
	localparam int PW      = 16;
	localparam int CNT_W   = $clog2(MAX_SHELVES + 1);
	localparam int ATLAS_W = $clog2(ATLAS_SIZE + 1);
	localparam int SUM_W   = (ATLAS_W > FW + 1) ? ATLAS_W : FW + 1;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERSIZE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic          mode;
		logic [FW-1:0] req_width;
		logic [FW-1:0] req_height;
	} req_t;

	typedef struct packed {
		logic [FW-1:0] left;
		logic [FW-1:0] top;
		logic [FW-1:0] row_height;
		logic [PW-1:0] page;
		logic [1:0]    status;
	} rsp_t;

	typedef struct packed {
		logic [FW-1:0] height;
		logic [FW-1:0] top;
		logic [FW-1:0] used;
		logic [PW-1:0] page;
	} shelf_t;

	typedef struct packed {
		logic          cmp_en;
		logic          hit_en;
		logic          ins_en;
		logic [FW-1:0] w;
		logic [FW-1:0] h;
		shelf_t        fresh;
	} cell_ctl_t;

endpackage

FILE: design/sac_cell.sv
`timescale 1ns / 1ps
module sac_cell (
	input  logic              clk,
	input  sac_pkg::cell_ctl_t ctl,
	input  logic              valid,
	input  logic              hit,
	input  logic              le_prev,
	input  sac_pkg::shelf_t   prev,
	output sac_pkg::shelf_t   shelf,
	output logic              le,
	output logic              fit
);
	import sac_pkg::*;

	shelf_t           shelf_q;
	logic             le_s1;
	logic             fit_s1;
	logic [SUM_W-1:0] room;

	assign room  = SUM_W'(shelf_q.used) + SUM_W'(ctl.w);
	assign shelf = shelf_q;
	assign le    = le_s1;
	assign fit   = fit_s1;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			le_s1  <= valid && (shelf_q.height <= ctl.h);
			fit_s1 <= valid && (shelf_q.height == ctl.h) && (room <= SUM_W'(ATLAS_SIZE));
		end
		if (ctl.hit_en && hit) begin
			shelf_q.used <= shelf_q.used + ctl.w;
		end else if (ctl.ins_en && !le_s1) begin
			// first cell past the insertion point takes the new shelf, the rest shift up
			if (le_prev) begin
				shelf_q <= ctl.fresh;
			end else begin
				shelf_q <= prev;
			end
		end
	end

endmodule

FILE: design/shelf_atlas_allocator_core.sv
`timescale 1ns / 1ps
// a result is registered in UPD after the compare in CMP; UPD holds on rsp_stall
// a new request is taken in IDLE or as UPD commits; a compare state across all
// shelf cells precedes an update that hits one cell or shifts the row to insert
// reset clears the shelf count, running top and page; shelf cells are not cleared
module shelf_atlas_allocator_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sac_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sac_pkg::rsp_t rsp
);
	import sac_pkg::*;

	typedef enum logic [1:0] {IDLE, CMP, UPD} state_t;

	state_t           state_q;
	req_t             req_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [FW-1:0]    next_top_q;
	logic [PW-1:0]    page_q;

	cell_ctl_t              ctl;
	shelf_t                 shelves [MAX_SHELVES];
	logic [MAX_SHELVES-1:0] le_vec;
	logic [MAX_SHELVES-1:0] fit_vec;
	logic [MAX_SHELVES-1:0] grant;
	logic [MAX_SHELVES-1:0] valid_vec;

	logic             can_finish;
	logic             accept;
	logic             commit;
	logic             oversize;
	logic             any_fit;
	logic             full;
	logic             new_fits;
	logic [SUM_W-1:0] top_sum;
	logic [FW-1:0]    new_top;
	logic [FW-1:0]    new_next;
	logic [PW-1:0]    new_page;
	shelf_t           hit_shelf;
	rsp_t             rsp_d;

	assign can_finish = !rsp_valid_q || !rsp_stall;
	assign req_stall  = !((state_q == IDLE) || (state_q == UPD && can_finish));
	assign accept     = req_valid && !req_stall;
	assign commit     = (state_q == UPD) && can_finish;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign oversize = (SUM_W'(req_q.req_width) > SUM_W'(ATLAS_SIZE))
		|| (SUM_W'(req_q.req_height) > SUM_W'(ATLAS_SIZE));
	assign any_fit  = |fit_vec;
	assign full     = (count_q == CNT_W'(MAX_SHELVES));
	// isolate the lowest fitting shelf
	assign grant    = fit_vec & (~fit_vec + MAX_SHELVES'(1));

	assign top_sum  = SUM_W'(next_top_q) + SUM_W'(req_q.req_height);
	assign new_fits = top_sum <= SUM_W'(ATLAS_SIZE);
	assign new_top  = new_fits ? next_top_q : '0;
	assign new_next = new_fits ? top_sum[FW-1:0] : req_q.req_height;
	assign new_page = new_fits ? page_q : page_q + PW'(1);

	always_comb begin
		hit_shelf = '0;
		for (int i = 0; i < MAX_SHELVES; i++) begin
			if (grant[i]) begin
				hit_shelf = hit_shelf | shelves[i];
			end
		end
	end

	always_comb begin
		ctl.cmp_en       = (state_q == CMP);
		ctl.hit_en       = commit && req_q.mode == MODE_ALLOC && !oversize && any_fit;
		ctl.ins_en       = commit && req_q.mode == MODE_ALLOC && !oversize && !any_fit && !full;
		ctl.w            = req_q.req_width;
		ctl.h            = req_q.req_height;
		ctl.fresh.height = req_q.req_height;
		ctl.fresh.top    = new_top;
		ctl.fresh.used   = req_q.req_width;
		ctl.fresh.page   = new_page;
	end

	always_comb begin
		rsp_d = '0;
		if (req_q.mode == MODE_ALLOC) begin
			if (oversize) begin
				rsp_d.status = ST_OVERSIZE;
			end else if (any_fit) begin
				rsp_d.left       = hit_shelf.used;
				rsp_d.top        = hit_shelf.top;
				rsp_d.row_height = req_q.req_height;
				rsp_d.page       = hit_shelf.page;
			end else if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				rsp_d.top        = new_top;
				rsp_d.row_height = req_q.req_height;
				rsp_d.page       = new_page;
			end
		end
	end

	for (genvar i = 0; i < MAX_SHELVES; i++) begin : g_cell
		assign valid_vec[i] = count_q > CNT_W'(i);
		if (i == 0) begin : g_first
			sac_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.valid   (valid_vec[i]),
				.hit     (grant[i]),
				.le_prev (1'b1),
				.prev    (shelves[i]),
				.shelf   (shelves[i]),
				.le      (le_vec[i]),
				.fit     (fit_vec[i])
			);
		end else begin : g_rest
			sac_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.valid   (valid_vec[i]),
				.hit     (grant[i]),
				.le_prev (le_vec[i-1]),
				.prev    (shelves[i-1]),
				.shelf   (shelves[i]),
				.le      (le_vec[i]),
				.fit     (fit_vec[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			req_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			next_top_q  <= '0;
			page_q      <= '0;
		end else begin
			if (accept) begin
				req_q <= req;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (commit && req_q.mode == MODE_CLEAR) begin
				count_q    <= '0;
				next_top_q <= '0;
			end else if (ctl.ins_en) begin
				count_q    <= count_q + CNT_W'(1);
				next_top_q <= new_next;
				page_q     <= new_page;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= CMP;
					end
				end
				CMP: begin
					state_q <= UPD;
				end
				UPD: begin
					if (can_finish) begin
						state_q <= accept ? CMP : IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule
